// File: src/url_percent_codec_core_assert.svh
`ifndef URL_PERCENT_CODEC_CORE_ASSERT_SVH
`define URL_PERCENT_CODEC_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UPC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UPC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/upc_pkg.sv
package upc_pkg;

	localparam logic [1:0] MODE_COMPONENT = 2'd0;
	localparam logic [1:0] MODE_PATH      = 2'd1;
	localparam logic [1:0] MODE_DECODE    = 2'd2;
	localparam logic [1:0] MODE_DECODE_ALT = 2'd3;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] HI_MASK  = 8'hF0;
	localparam logic [7:0] LO_MASK  = 8'h0F;

	localparam logic [7:0] HEX_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_PCT   = 2'd1,
		PEND_DIGIT = 2'd2
	} pend_t;

	typedef struct packed {
		pend_t       pend;
		logic [3:0]  nib;
		logic [7:0]  chr;
	} dec_state_t;

	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            last;
	} res_t;

	function automatic logic is_unreserved(input logic [7:0] b);
		return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h2D, 8'h5F, 8'h2E, CH_TILDE});
	endfunction

	function automatic logic is_path_kept(input logic [7:0] b);
		return is_unreserved(b) || (b inside {8'h2F, CH_PCT, 8'h3F, 8'h3D, 8'h26,
			8'h23, CH_STAR});
	endfunction

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b inside {[8'h30:8'h39]})
			v = {1'b0, 4'(b - 8'h30)};
		else if (b inside {[8'h41:8'h46]})
			v = {1'b0, 4'(b - 8'h37)};
		else if (b inside {[8'h61:8'h66]})
			v = {1'b0, 4'(b - 8'h57)};
		return v;
	endfunction

endpackage

// File: src/upc_step.sv
module upc_step (
	input  logic [1:0]          mode,
	input  upc_pkg::dec_state_t st,
	input  logic [7:0]          in_byte,
	input  logic                string_last,
	output upc_pkg::res_t       res,
	output upc_pkg::dec_state_t st_next
);

	logic [4:0] hv;
	logic       hx;
	logic       fresh_emit;
	logic       keep;
	logic [7:0] hi;
	logic [7:0] lo;

	always_comb begin
		hv         = upc_pkg::hex_value(in_byte);
		hx         = !hv[4];
		fresh_emit = !(in_byte == upc_pkg::CH_PCT && !string_last);
		keep       = (mode == upc_pkg::MODE_COMPONENT) ? upc_pkg::is_unreserved(in_byte)
			: upc_pkg::is_path_kept(in_byte);
		hi         = (in_byte & upc_pkg::HI_MASK) >> 4;
		lo         = in_byte & upc_pkg::LO_MASK;

		res.cnt    = 2'd0;
		res.bytes  = '0;
		res.last   = string_last;
		st_next    = st;

		if (mode == upc_pkg::MODE_COMPONENT || mode == upc_pkg::MODE_PATH) begin
			if (keep) begin
				res.cnt      = 2'd1;
				res.bytes[0] = in_byte;
			end else begin
				res.cnt      = 2'd3;
				res.bytes[0] = upc_pkg::CH_PCT;
				res.bytes[1] = upc_pkg::HEX_CHARS[hi[3:0]];
				res.bytes[2] = upc_pkg::HEX_CHARS[lo[3:0]];
			end
		end else begin
			case (st.pend)
				upc_pkg::PEND_NONE: begin
					if (fresh_emit) begin
						res.cnt      = 2'd1;
						res.bytes[0] = in_byte;
					end else begin
						st_next.pend = upc_pkg::PEND_PCT;
					end
				end
				upc_pkg::PEND_PCT: begin
					if (hx && !string_last) begin
						st_next.pend = upc_pkg::PEND_DIGIT;
						st_next.nib  = hv[3:0];
						st_next.chr  = in_byte;
					end else begin
						res.bytes[0] = upc_pkg::CH_PCT;
						res.bytes[1] = in_byte;
						res.cnt      = fresh_emit ? 2'd2 : 2'd1;
						st_next.pend = fresh_emit ? upc_pkg::PEND_NONE : upc_pkg::PEND_PCT;
					end
				end
				upc_pkg::PEND_DIGIT: begin
					st_next.pend = upc_pkg::PEND_NONE;
					st_next.nib  = 4'd0;
					st_next.chr  = 8'd0;
					if (hx) begin
						res.cnt      = 2'd1;
						res.bytes[0] = {st.nib, hv[3:0]};
					end else begin
						res.bytes[0] = upc_pkg::CH_PCT;
						res.bytes[1] = st.chr;
						res.bytes[2] = in_byte;
						res.cnt      = fresh_emit ? 2'd3 : 2'd2;
						if (!fresh_emit)
							st_next.pend = upc_pkg::PEND_PCT;
					end
				end
				default: begin
					st_next.pend = upc_pkg::PEND_NONE;
				end
			endcase
		end
	end

endmodule

// File: src/upc_ser.sv
module upc_ser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  upc_pkg::res_t load_res,
	output logic          free,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [7:0]    m_axis_tdata,  // out_byte
	output logic [0:0]    m_axis_tuser,  // run_last
	output logic          m_axis_tlast   // string_end
);

	upc_pkg::res_t res_s2;
	logic          valid_s2;
	logic [1:0]    idx_q;
	logic          last_beat;

	assign last_beat     = (idx_q == res_s2.cnt - 2'd1);
	assign free          = !valid_s2 || (m_axis_tready && last_beat);
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2.bytes[idx_q];
	assign m_axis_tuser  = last_beat;
	assign m_axis_tlast  = last_beat && res_s2.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (valid_s2 && m_axis_tready) begin
			if (last_beat)
				valid_s2 <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s2 <= load_res;
	end

endmodule

// File: src/url_percent_codec_core.sv
// URL percent codec on a byte stream. mode 0 escapes every byte that is not
// unreserved, mode 1 also passes / % ? = & # *, modes 2 and 3 decode %XX
// escapes (either case) and pass malformed escapes through literally.
// Writing mode drops any escape held in decode. One input byte is taken per
// cycle while the skid buffer is empty; output bytes leave one per cycle while
// the receiver is ready, so an escaped byte puts three bytes on the single
// output byte lane and a held '%' or hex digit none. A one-entry skid buffer
// parks a result while the lane is busy; intake stops while it is full.
module url_percent_codec_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte
	input  logic       s_axis_tlast,   // string_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic [0:0] m_axis_tuser,   // run_last
	output logic       m_axis_tlast    // string_end
);

	logic [1:0]          mode_q;
	upc_pkg::dec_state_t st_q;
	upc_pkg::dec_state_t st_next;
	upc_pkg::res_t       res;
	upc_pkg::res_t       skid_q;
	logic                skid_valid_q;
	logic                accept;
	logic                has_out;
	logic                ser_free;
	logic                load;

	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign has_out       = (res.cnt != 2'd0);
	assign load          = ser_free && (skid_valid_q || (accept && has_out));

	upc_step u_step (
		.mode        (mode_q),
		.st          (st_q),
		.in_byte     (s_axis_tdata),
		.string_last (s_axis_tlast),
		.res         (res),
		.st_next     (st_next)
	);

	upc_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.load_res      (skid_valid_q ? skid_q : res),
		.free          (ser_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= upc_pkg::MODE_COMPONENT;
			st_q.pend    <= upc_pkg::PEND_NONE;
			st_q.nib     <= 4'd0;
			st_q.chr     <= 8'd0;
		end else if (cfg_we) begin
			mode_q       <= cfg_wdata;
			st_q.pend    <= upc_pkg::PEND_NONE;
			st_q.nib     <= 4'd0;
			st_q.chr     <= 8'd0;
		end else if (accept) begin
			st_q         <= st_next;
		end
	end

	// park a request when the output lane cannot take it this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (accept && has_out && !ser_free) begin
			skid_valid_q <= 1'b1;
		end else if (ser_free && skid_valid_q) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_out && !ser_free)
			skid_q <= res;
	end

endmodule

// File: src/upc_checker.sv
`include "url_percent_codec_core_assert.svh"

module upc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [0:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	`UPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output request dropped while stalled")
	`UPC_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output byte changed while stalled")
	`UPC_ASSERT_NOW(a_end_is_run_end, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "string end not on last byte of its run")
	`UPC_ASSERT_NOW(a_ready_fall, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tready), "input ready fell without an accepted request")

endmodule

bind url_percent_codec_core upc_checker u_upc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// File: tb/testbench.sv
module testbench;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 350;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       str_end;
	} out_item_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic       m_axis_tlast;

	out_item_t       expected_bytes[$];
	logic [7:0]      step_bytes[$];
	logic [1:0]      mode_shadow;
	upc_pkg::pend_t  esc_state;
	logic [3:0]      esc_nib;
	logic [7:0]      esc_chr;
	int              fail_count;
	int              sent_count;
	int              rx_hold;
	bit              tx_gaps_on;
	bit              rx_gaps_on;

	url_percent_codec_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [4:0] hex_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return {1'b0, 4'(c - 8'h30)};
		if (c >= 8'h41 && c <= 8'h46)
			return {1'b0, 4'(c - 8'h41 + 8'd10)};
		if (c >= 8'h61 && c <= 8'h66)
			return {1'b0, 4'(c - 8'h61 + 8'd10)};
		return 5'h10;
	endfunction

	function automatic logic passes_plain(input logic [1:0] m, input logic [7:0] c);
		logic keep;
		keep = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F ||
			c == 8'h2E || c == upc_pkg::CH_TILDE;
		if (m == upc_pkg::MODE_PATH)
			keep = keep || c == 8'h2F || c == upc_pkg::CH_PCT || c == 8'h3F ||
				c == 8'h3D || c == 8'h26 || c == 8'h23 || c == upc_pkg::CH_STAR;
		return keep;
	endfunction

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'(8'h30 + v);
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic void fresh_byte(input logic [7:0] b, input logic last);
		if (b == upc_pkg::CH_PCT && !last)
			esc_state = upc_pkg::PEND_PCT;
		else
			step_bytes.push_back(b);
	endfunction

	function automatic void predict_codec_step(input logic [7:0] b, input logic last);
		logic [4:0] hv;
		out_item_t  item;
		hv = hex_of(b);
		step_bytes.delete();
		if (mode_shadow == upc_pkg::MODE_COMPONENT || mode_shadow == upc_pkg::MODE_PATH) begin
			if (passes_plain(mode_shadow, b)) begin
				step_bytes.push_back(b);
			end else begin
				step_bytes.push_back(upc_pkg::CH_PCT);
				step_bytes.push_back(upc_pkg::HEX_CHARS[b[7:4]]);
				step_bytes.push_back(upc_pkg::HEX_CHARS[b[3:0]]);
			end
		end else if (esc_state == upc_pkg::PEND_NONE) begin
			fresh_byte(b, last);
		end else if (esc_state == upc_pkg::PEND_PCT) begin
			if (!hv[4] && !last) begin
				esc_nib   = hv[3:0];
				esc_chr   = b;
				esc_state = upc_pkg::PEND_DIGIT;
			end else begin
				esc_state = upc_pkg::PEND_NONE;
				step_bytes.push_back(upc_pkg::CH_PCT);
				fresh_byte(b, last);
			end
		end else begin
			esc_state = upc_pkg::PEND_NONE;
			if (!hv[4]) begin
				step_bytes.push_back({esc_nib, hv[3:0]});
			end else begin
				step_bytes.push_back(upc_pkg::CH_PCT);
				step_bytes.push_back(esc_chr);
				fresh_byte(b, last);
			end
			esc_nib = '0;
			esc_chr = '0;
		end
		foreach (step_bytes[i]) begin
			item.data     = step_bytes[i];
			item.run_last = (i == step_bytes.size() - 1);
			item.str_end  = item.run_last && last;
			expected_bytes.push_back(item);
		end
	endfunction

	function automatic void check_output(input logic [7:0] d, input logic rl, input logic se);
		out_item_t want;
		if (expected_bytes.size() == 0) begin
			$display("%0t: unexpected output byte %h run_last %b string_end %b",
				$time, d, rl, se);
			fail_count++;
		end else begin
			want = expected_bytes.pop_front();
			if (d !== want.data) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.data, d);
				fail_count++;
			end
			if (rl !== want.run_last) begin
				$display("%0t: run_last expected %b actual %b", $time, want.run_last, rl);
				fail_count++;
			end
			if (se !== want.str_end) begin
				$display("%0t: string_end expected %b actual %b", $time, want.str_end, se);
				fail_count++;
			end
		end
	endfunction

	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_codec_step(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_output(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : receiver
		int gap;
		gap = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold--;
			end else if (gap > 0) begin
				m_axis_tready <= 1'b0;
				gap--;
			end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				gap = gap_len() - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		// hold the request until taken
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		sent_count++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		drain_outputs();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we      <= 1'b0;
		mode_shadow = m;
		esc_state   = upc_pkg::PEND_NONE;
		esc_nib     = '0;
		esc_chr     = '0;
	endtask

	task automatic test_component_encode();
		write_mode(upc_pkg::MODE_COMPONENT);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("a~ %");
	endtask

	task automatic test_path_encode();
		write_mode(upc_pkg::MODE_PATH);
		send_text("/%?=&#*+");
	endtask

	task automatic test_decode_escapes();
		write_mode(upc_pkg::MODE_DECODE);
		send_text("%41%%4a%4G%4");
		send_text("%");
		write_mode(upc_pkg::MODE_DECODE_ALT);
		send_text("%2f");
	endtask

	task automatic test_mode_write_discards();
		write_mode(upc_pkg::MODE_DECODE);
		send_byte(upc_pkg::CH_PCT, 1'b0);
		send_byte(8'h34, 1'b0);
		write_mode(upc_pkg::MODE_DECODE);
		send_byte(8'h78, 1'b1);
	endtask

	task automatic test_backpressure();
		write_mode(upc_pkg::MODE_COMPONENT);
		tx_gaps_on = 1'b0;
		rx_hold    = 150;
		for (int i = 0; i < 30; i++)
			send_byte(8'($urandom_range(0, 8'h2C)), i == 29);
		drain_outputs();
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_strings();
		logic [7:0] text[$];
		logic [1:0] m;
		int         phase;
		int         kind;
		int         stop_at;
		int         phase_end;
		phase   = 0;
		stop_at = sent_count + RANDOM_ITEMS;
		while (sent_count < stop_at) begin
			if (phase == 0)
				m = upc_pkg::MODE_COMPONENT;
			else if (phase == 1)
				m = upc_pkg::MODE_DECODE_ALT;
			else begin
				kind = $urandom_range(0, 5);
				m = (kind > 3) ? upc_pkg::MODE_DECODE : 2'(kind);
			end
			write_mode(m);
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on = ($urandom_range(0, 3) != 0);
			phase_end  = sent_count + $urandom_range(20, 50);
			if (phase_end > stop_at)
				phase_end = stop_at;
			while (sent_count < phase_end) begin
				text.delete();
				repeat ($urandom_range(1, 8)) begin
					kind = $urandom_range(0, 9);
					if (m == upc_pkg::MODE_COMPONENT || m == upc_pkg::MODE_PATH) begin
						if (kind < 3)
							text.push_back(8'($urandom_range(0, 255)));
						else
							text.push_back(8'($urandom_range(8'h20, 8'h7E)));
					end else if (kind < 4) begin
						text.push_back(8'($urandom_range(0, 255)));
					end else if (kind < 8) begin
						text.push_back(upc_pkg::CH_PCT);
						text.push_back(random_hex_char());
						text.push_back(random_hex_char());
					end else if (kind == 8) begin
						text.push_back(upc_pkg::CH_PCT);
						text.push_back(random_hex_char());
						text.push_back(8'($urandom_range(0, 255)));
					end else begin
						text.push_back(upc_pkg::CH_PCT);
					end
				end
				foreach (text[i])
					send_byte(text[i], i == text.size() - 1);
			end
			phase++;
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = upc_pkg::MODE_COMPONENT;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		fail_count    = 0;
		sent_count    = 0;
		rx_hold       = 0;
		tx_gaps_on    = 1'b1;
		rx_gaps_on    = 1'b1;
		mode_shadow   = upc_pkg::MODE_COMPONENT;
		esc_state     = upc_pkg::PEND_NONE;
		esc_nib       = '0;
		esc_chr       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_component_encode();
		test_path_encode();
		test_decode_escapes();
		test_mode_write_discards();
		test_backpressure();
		test_random_strings();
		drain_outputs();
		if (expected_bytes.size() != 0) begin
			$display("%0t: %0d expected output bytes never arrived", $time,
				expected_bytes.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
